### hw/rtl/rif_pkg.sv
package rif_pkg;

    // section table geometry
    localparam int MAX_SECTIONS = 8;
    localparam int SECT_IDX_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SECT_CNT_W   = $clog2(MAX_SECTIONS + 1);

    localparam logic [31:0] ROM_BASE_RESET = 32'h4020_0800;
    localparam logic [31:0] IMM_KEEP_MASK  = 32'hFBF0_8F00;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_RELOC = 1'b1;

    // relocation type codes
    localparam logic [3:0] RELOC_ABS       = 4'd0;
    localparam logic [3:0] RELOC_HIGHLOW   = 4'd3;
    localparam logic [3:0] RELOC_MOVW_MOVT = 4'd7;

    typedef struct packed {
        logic        command;
        logic [2:0]  section_index;
        logic [31:0] section_start_in;
        logic [31:0] section_size_in;
        logic        section_kept_in;
        logic [3:0]  reloc_type;
        logic [31:0] first_word;
        logic [31:0] second_word;
    } rif_in_t;

    typedef struct packed {
        logic [31:0] first_word_out;
        logic [31:0] second_word_out;
        logic        type_error;
    } rif_out_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        kept;
    } rif_sect_t;

    typedef struct packed {
        logic        start;
        logic [31:0] addr;
    } rif_scan_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } rif_scan_rsp_t;

    // movw/movt immediate: imm4 19:16, i 26, imm3 14:12, imm8 7:0
    function automatic logic [15:0] decode_imm16(input logic [31:0] w);
        return {w[19:16], w[26], w[14:12], w[7:0]};
    endfunction

    function automatic logic [31:0] encode_imm16(input logic [31:0] w,
                                                 input logic [15:0] v);
        logic [31:0] imm;
        imm        = '0;
        imm[19:16] = v[15:12];
        imm[26]    = v[11];
        imm[14:12] = v[10:8];
        imm[7:0]   = v[7:0];
        return (w & IMM_KEEP_MASK) | imm;
    endfunction

endpackage

### hw/rtl/rif_sect_table.sv
module rif_sect_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [2:0]                          wr_index,
    input  rif_pkg::rif_sect_t                  wr_entry,
    input  logic [rif_pkg::SECT_IDX_W-1:0]      rd_addr,
    output rif_pkg::rif_sect_t                  rd_data,
    output logic [rif_pkg::SECT_CNT_W-1:0]      count
);

    rif_pkg::rif_sect_t                 mem [rif_pkg::MAX_SECTIONS];
    logic [rif_pkg::MAX_SECTIONS-1:0]   valid_reg;
    logic [rif_pkg::SECT_CNT_W-1:0]     count_reg;
    rif_pkg::rif_sect_t                 rd_data_reg;
    logic                               wr_ok;
    logic [rif_pkg::SECT_IDX_W-1:0]     wr_addr;

    // out-of-range slots are dropped
    assign wr_ok   = wr_en && (int'(wr_index) < rif_pkg::MAX_SECTIONS);
    assign wr_addr = rif_pkg::SECT_IDX_W'(wr_index);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= wr_entry;
        end
        // never-loaded slots read as zero
        if (valid_reg[rd_addr]) begin
            rd_data_reg <= mem[rd_addr];
        end else begin
            rd_data_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else if (wr_ok) begin
            valid_reg[wr_addr] <= 1'b1;
            count_reg          <= rif_pkg::SECT_CNT_W'(int'(wr_index) + 1);
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

### hw/rtl/rif_remap.sv
module rif_remap (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rif_pkg::rif_scan_req_t              req,
    input  logic [31:0]                         rom_base,
    input  logic [rif_pkg::SECT_CNT_W-1:0]      count,
    output logic [rif_pkg::SECT_IDX_W-1:0]      rd_addr,
    input  rif_pkg::rif_sect_t                  rd_data,
    output rif_pkg::rif_scan_rsp_t              rsp
);

    typedef enum logic [5:0] {
        R_IDLE  = 6'b000001,
        R_READ  = 6'b000010,
        R_CHECK = 6'b000100,
        R_ACC   = 6'b001000,
        R_BASE  = 6'b010000,
        R_DONE  = 6'b100000
    } rmp_state_t;

    rmp_state_t                     state_reg, state_next;
    logic [rif_pkg::SECT_CNT_W-1:0] idx_reg, idx_next, idx_inc;
    logic [31:0]                    addr_reg, addr_next;
    logic [31:0]                    off_reg, off_next;
    logic [31:0]                    diff_reg, diff_next;
    logic                           hit_reg, hit_next;
    logic [31:0]                    result_reg, result_next;

    // shared adder
    logic [31:0] alu_a, alu_b;
    logic        alu_cin;
    logic [32:0] alu_sum;

    assign idx_inc = idx_reg + rif_pkg::SECT_CNT_W'(1);
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_cin};

    always_comb begin
        alu_a   = off_reg;
        alu_b   = rom_base;
        alu_cin = 1'b0;
        case (state_reg)
            R_CHECK: begin
                // addr - start, carry out set when addr >= start
                alu_a   = addr_reg;
                alu_b   = ~rd_data.start;
                alu_cin = 1'b1;
            end
            R_ACC: begin
                alu_a = off_reg;
                if (hit_reg) begin
                    alu_b = diff_reg;
                end else if (rd_data.kept) begin
                    alu_b = rd_data.size;
                end else begin
                    alu_b = '0;
                end
            end
            default: begin
                alu_a = off_reg;
                alu_b = rom_base;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        addr_next   = addr_reg;
        off_next    = off_reg;
        diff_next   = diff_reg;
        hit_next    = hit_reg;
        result_next = result_reg;
        rd_addr     = idx_reg[rif_pkg::SECT_IDX_W-1:0];
        case (state_reg)
            R_IDLE: begin
                if (req.start) begin
                    addr_next = req.addr;
                    idx_next  = '0;
                    off_next  = '0;
                    if (count == '0) begin
                        state_next = R_BASE;
                    end else begin
                        state_next = R_READ;
                    end
                end
            end
            R_READ: begin
                state_next = R_CHECK;
            end
            R_CHECK: begin
                // inside when start <= addr and addr - start < size
                diff_next  = alu_sum[31:0];
                hit_next   = alu_sum[32] && (alu_sum[31:0] < rd_data.size);
                state_next = R_ACC;
            end
            R_ACC: begin
                off_next = alu_sum[31:0];
                // prefetch next entry while accumulating
                rd_addr  = idx_inc[rif_pkg::SECT_IDX_W-1:0];
                if (hit_reg || idx_inc == count) begin
                    state_next = R_BASE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = R_CHECK;
                end
            end
            R_BASE: begin
                result_next = alu_sum[31:0];
                state_next  = R_DONE;
            end
            R_DONE: begin
                state_next = R_IDLE;
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        off_reg    <= off_next;
        diff_reg   <= diff_next;
        hit_reg    <= hit_next;
        result_reg <= result_next;
    end

    assign rsp.done   = (state_reg == R_DONE);
    assign rsp.result = result_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == R_IDLE)
        else $error("scan started while busy");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == R_CHECK |-> idx_reg < count)
        else $error("scan index past section count");

    a_done_after_base: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == R_DONE |-> $past(state_reg) == R_BASE)
        else $error("done without base add");

    a_check_keeps_off: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == R_CHECK |=> $stable(off_reg))
        else $error("offset changed during range check");

endmodule

### hw/rtl/image_relocation_fixup.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------
// s_        | in        | s_valid / s_ready  | rif_in_t: load or relocate
// m_        | out       | m_valid / m_ready  | rif_out_t: one per relocate
// cfg_      | in        | cfg_wr_en          | rom_base, no wait, no read-back
//
// loads: section load requests can follow back to back.
// a type 3 or type 7 relocation visits the sections in order up to and including
// the hit (all loaded sections on a miss), at most eight; its cost is the
// section scan through the one shared 33-bit adder.
// type 0 and unknown types skip the scan.
// reset: synchronous active-low aresetn empties the section table (valid bits
// and count) and sets rom_base to 0x40200800.
// stalls: a held result in the output register does not block loads or the
// next scan; only the final write of a new result waits for m_ready.
module image_relocation_fixup (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rif_pkg::rif_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rif_pkg::rif_out_t   m_data,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_SCAN = 3'b010,
        T_OUT  = 3'b100
    } top_state_t;

    top_state_t                     state_reg, state_next;
    logic [3:0]                     type_reg, type_next;
    logic [31:0]                    w1_reg, w1_next;
    logic [31:0]                    w2_reg, w2_next;
    logic [31:0]                    rom_base_reg;
    logic                           m_valid_reg, m_valid_next;
    rif_pkg::rif_out_t              m_data_reg, m_data_next;

    logic                           accept;
    logic                           load_req;
    logic                           reloc_req;
    logic                           needs_scan;
    rif_pkg::rif_sect_t             wr_entry;
    rif_pkg::rif_sect_t             rd_data;
    logic [rif_pkg::SECT_IDX_W-1:0] rd_addr;
    logic [rif_pkg::SECT_CNT_W-1:0] count;
    rif_pkg::rif_scan_req_t         scan_req;
    rif_pkg::rif_scan_rsp_t         scan_rsp;
    rif_pkg::rif_out_t              out_word;
    logic                           out_free;

    assign s_ready   = (state_reg == T_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_req  = accept && (s_data.command == rif_pkg::CMD_LOAD);
    assign reloc_req = accept && (s_data.command == rif_pkg::CMD_RELOC);

    // only pointer and movw/movt relocations go through the section scan
    assign needs_scan = (s_data.reloc_type == rif_pkg::RELOC_HIGHLOW) ||
                        (s_data.reloc_type == rif_pkg::RELOC_MOVW_MOVT);

    assign wr_entry.start = s_data.section_start_in;
    assign wr_entry.size  = s_data.section_size_in;
    assign wr_entry.kept  = s_data.section_kept_in;

    // scan target: the pointer itself, or the movw immediate
    assign scan_req.start = reloc_req && needs_scan;
    assign scan_req.addr  = (s_data.reloc_type == rif_pkg::RELOC_MOVW_MOVT) ?
                            {16'd0, rif_pkg::decode_imm16(s_data.first_word)} :
                            s_data.first_word;

    rif_sect_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (load_req),
        .wr_index (s_data.section_index),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .count    (count)
    );

    rif_remap u_remap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (scan_req),
        .rom_base (rom_base_reg),
        .count    (count),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rsp      (scan_rsp)
    );

    // result patching from the held request and the remapped address
    always_comb begin
        out_word.first_word_out  = w1_reg;
        out_word.second_word_out = w2_reg;
        out_word.type_error      = 1'b0;
        case (type_reg)
            rif_pkg::RELOC_ABS: begin
                out_word.type_error = 1'b0;
            end
            rif_pkg::RELOC_HIGHLOW: begin
                out_word.first_word_out = scan_rsp.result;
            end
            rif_pkg::RELOC_MOVW_MOVT: begin
                out_word.first_word_out  =
                    rif_pkg::encode_imm16(w1_reg, scan_rsp.result[15:0]);
                out_word.second_word_out =
                    rif_pkg::encode_imm16(w2_reg, scan_rsp.result[31:16]);
            end
            default: begin
                // unknown type: words unchanged, flag raised
                out_word.type_error = 1'b1;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        type_next    = type_reg;
        w1_next      = w1_reg;
        w2_next      = w2_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            T_IDLE: begin
                if (reloc_req) begin
                    type_next = s_data.reloc_type;
                    w1_next   = s_data.first_word;
                    w2_next   = s_data.second_word;
                    if (needs_scan) begin
                        state_next = T_SCAN;
                    end else begin
                        state_next = T_OUT;
                    end
                end
            end
            T_SCAN: begin
                if (scan_rsp.done) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (out_free) begin
                    m_data_next  = out_word;
                    m_valid_next = 1'b1;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_valid_reg  <= 1'b0;
            rom_base_reg <= rif_pkg::ROM_BASE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                rom_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg   <= type_next;
        w1_reg     <= w1_next;
        w2_reg     <= w2_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/sv/tb_image_relocation_fixup.sv
module tb_image_relocation_fixup;
    import rif_pkg::*;

    // longest stretch with no request or result moving before we give up
    localparam int WATCHDOG_LIMIT = 2000;
    // longer than the worst relocation, so this covers anything still in flight
    localparam int SETTLE_CYCLES  = 32;
    localparam int MAX_REPORTS    = 200;

    // tracks the section table and rom_base, and holds the patched words
    // expected back, oldest first
    class fixup_tracker;
        logic [31:0]           rom_base;
        rif_sect_t             sections[MAX_SECTIONS];
        logic [SECT_CNT_W-1:0] loaded_count;
        rif_out_t              patched_q[$];
        int                    errors;

        function new();
            rom_base     = ROM_BASE_RESET;
            loaded_count = '0;
            errors       = 0;
            foreach (sections[i]) sections[i] = '0;
        endfunction

        // movw/movt immediate: imm4 19:16, i 26, imm3 14:12, imm8 7:0
        static function logic [15:0] imm16_of(logic [31:0] w);
            logic [15:0] v;
            v[15:12] = w[19:16];
            v[11]    = w[26];
            v[10:8]  = w[14:12];
            v[7:0]   = w[7:0];
            return v;
        endfunction

        static function logic [31:0] with_imm16(logic [31:0] w, logic [15:0] v);
            logic [31:0] r;
            r        = w;
            r[19:16] = v[15:12];
            r[26]    = v[11];
            r[14:12] = v[10:8];
            r[7:0]   = v[7:0];
            return r;
        endfunction

        // first section holding addr wins; kept sections scanned before it add their size
        function logic [31:0] remap_address(logic [31:0] addr);
            logic [31:0] offset;
            logic [32:0] limit;
            offset = '0;
            for (int i = 0; i < loaded_count && i < MAX_SECTIONS; i++) begin
                limit = {1'b0, sections[i].start} + {1'b0, sections[i].size};
                if (addr >= sections[i].start && {1'b0, addr} < limit) begin
                    return rom_base + offset + (addr - sections[i].start);
                end
                if (sections[i].kept) offset += sections[i].size;
            end
            return rom_base + offset;
        endfunction

        function void note_request(rif_in_t req);
            rif_out_t    res;
            logic [31:0] target;
            if (req.command == CMD_LOAD) begin
                sections[req.section_index].start = req.section_start_in;
                sections[req.section_index].size  = req.section_size_in;
                sections[req.section_index].kept  = req.section_kept_in;
                loaded_count = SECT_CNT_W'(int'(req.section_index) + 1);
                return;
            end
            res.first_word_out  = req.first_word;
            res.second_word_out = req.second_word;
            res.type_error      = 1'b0;
            case (req.reloc_type)
                RELOC_ABS: begin
                end
                RELOC_HIGHLOW: begin
                    res.first_word_out = remap_address(req.first_word);
                end
                RELOC_MOVW_MOVT: begin
                    target = remap_address({16'h0, imm16_of(req.first_word)});
                    res.first_word_out  = with_imm16(req.first_word, target[15:0]);
                    res.second_word_out = with_imm16(req.second_word, target[31:16]);
                end
                default: begin
                    res.type_error = 1'b1;
                end
            endcase
            patched_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
        endtask

        task check_patched(rif_out_t got);
            rif_out_t want;
            if (patched_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = patched_q.pop_front();
            if (got.first_word_out !== want.first_word_out ||
                got.second_word_out !== want.second_word_out ||
                got.type_error !== want.type_error) begin
                report_mismatch($sformatf(
                    "first %h/%h second %h/%h error %b/%b (got/want)",
                    got.first_word_out, want.first_word_out,
                    got.second_word_out, want.second_word_out,
                    got.type_error, want.type_error));
            end
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    rif_in_t     s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    rif_out_t    m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    fixup_tracker sb = new();

    // sender burst bookkeeping and a stimulus-side copy of the table,
    // used to aim relocation addresses at loaded sections
    int          burst_left = 0;
    logic [31:0] tbl_start[MAX_SECTIONS];
    logic [31:0] tbl_size[MAX_SECTIONS];
    int          tbl_n = 0;

    // receiver stall pattern
    int          stall_left = 0;
    int          stall_pct  = 0;
    int          rx_cycle   = 0;
    int          quiet_cycles = 0;

    image_relocation_fixup u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: ready by default, random stalls whose rate shifts at regular
    // intervals between none, light and heavy
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct <= 0;
                1: stall_pct <= 15;
                default: stall_pct <= 60;
            endcase
        end
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 12);
        end
    end

    // monitors: the request is noted before any result of the same edge is checked
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (aresetn && m_valid && m_ready) sb.check_patched(m_data);
    end

    // watchdog on cycles where neither channel moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("image_relocation_fixup test failed");
            $finish;
        end
    end

    // present one request and hold it until accepted; valid stays high
    // afterwards so the next request can follow back to back
    task automatic push_request(input rif_in_t req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // section load request; relocation fields carry noise
    task automatic push_load(input logic [2:0] idx, input logic [31:0] start,
                             input logic [31:0] size, input logic kept);
        rif_in_t req;
        req.command          = CMD_LOAD;
        req.section_index    = idx;
        req.section_start_in = start;
        req.section_size_in  = size;
        req.section_kept_in  = kept;
        req.reloc_type       = 4'($urandom);
        req.first_word       = $urandom;
        req.second_word      = $urandom;
        tbl_start[idx] = start;
        tbl_size[idx]  = size;
        tbl_n          = idx + 1;
        push_request(req);
    endtask

    // relocation request; section fields carry noise
    task automatic push_reloc(input logic [3:0] kind, input logic [31:0] w1,
                              input logic [31:0] w2);
        rif_in_t req;
        req.command          = CMD_RELOC;
        req.section_index    = 3'($urandom);
        req.section_start_in = $urandom;
        req.section_size_in  = $urandom;
        req.section_kept_in  = 1'($urandom);
        req.reloc_type       = kind;
        req.first_word       = w1;
        req.second_word      = w2;
        push_request(req);
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic hold_until_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.patched_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // rom_base write, only ever issued with the block idle
    task automatic write_rom_base(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.rom_base = value;
    endtask

    initial begin
        int          n_sect;
        int          n_reloc;
        int          k;
        int          r;
        bit          narrow;
        logic [31:0] addr;
        logic [31:0] cur;
        logic [31:0] sz;
        logic [31:0] base_val;
        logic [3:0]  kind;

        foreach (tbl_start[i]) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // every type code against an empty table, words at all-ones and all-zeros
        for (int t = 0; t < 16; t++) begin
            push_reloc(4'(t), (t % 2 == 0) ? 32'hFFFF_FFFF : 32'h0,
                       (t % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF);
        end

        // kept, dropped, and a section running to the top of the address space
        push_load(3'd0, 32'h0000_1000, 32'h0000_2000, 1'b1);
        push_load(3'd1, 32'h0000_3000, 32'h0000_1000, 1'b0);
        push_load(3'd2, 32'h0000_4000, 32'hFFFF_FFFF, 1'b1);
        push_reloc(RELOC_HIGHLOW, 32'h0000_1000, 32'h0);
        // last byte of a dropped section
        push_reloc(RELOC_HIGHLOW, 32'h0000_3FFF, 32'hFFFF_FFFF);
        push_reloc(RELOC_MOVW_MOVT, fixup_tracker::with_imm16(32'hFFFF_FFFF, 16'h3000),
                   32'hFFFF_FFFF);
        // offset wraps past 2^32
        push_reloc(RELOC_HIGHLOW, 32'hFFFF_FFFF, 32'h0);
        // below every section: miss, sum of kept sizes wraps
        push_reloc(RELOC_HIGHLOW, 32'h0000_0FFF, 32'h0);
        // top slot with never-written slots in between, full eight-entry scan
        push_load(3'd7, 32'h0, 32'h0, 1'b1);
        push_reloc(RELOC_HIGHLOW, 32'h0000_0FFF, 32'h0);
        push_reloc(RELOC_MOVW_MOVT, 32'h0, 32'h0);

        for (int p = 0; p < 24; p++) begin
            // rom_base changes every third phase, extremes first
            if (p % 3 == 0) begin
                hold_until_drained();
                case ((p / 3) % 5)
                    0: base_val = 32'h0;
                    1: base_val = 32'hFFFF_FFFF;
                    2: base_val = $urandom;
                    3: base_val = 32'h8000_0000;
                    default: base_val = ROM_BASE_RESET;
                endcase
                write_rom_base(base_val);
            end

            // build a table: narrow ones sit below 64k so movw/movt can reach them
            narrow = $urandom_range(0, 1);
            n_sect = $urandom_range(1, MAX_SECTIONS);
            cur    = narrow ? $urandom_range(0, 'h800) : $urandom;
            for (int i = 0; i < n_sect; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_load(3'($urandom), $urandom, $urandom, 1'($urandom));
                end
                if ($urandom_range(0, 9) == 0) sz = 32'h0;
                else if (narrow) sz = $urandom_range(1, 'h1800);
                else if ($urandom_range(0, 9) == 0) sz = $urandom;
                else sz = $urandom_range(1, 'hF_FFFF);
                push_load(3'(i), cur, sz, 1'($urandom));
                cur = cur + sz + (narrow ? $urandom_range(0, 'h200) : $urandom_range(0, 'hFFFF));
            end

            n_reloc = $urandom_range(18, 30);
            for (int j = 0; j < n_reloc; j++) begin
                // the occasional stray load mid-stream moves the section count around
                if ($urandom_range(0, 19) == 0) begin
                    push_load(3'($urandom), narrow ? $urandom_range(0, 'hFFFF) : $urandom,
                              $urandom_range(0, 'h2000), 1'($urandom));
                end

                // aim: inside a section, just past its end, just before its start, or anywhere
                k = $urandom_range(0, tbl_n - 1);
                r = $urandom_range(0, 99);
                if (r < 70 && tbl_size[k] != 0) addr = tbl_start[k] + ($urandom % tbl_size[k]);
                else if (r < 80) addr = tbl_start[k] + tbl_size[k];
                else if (r < 85) addr = tbl_start[k] - 1;
                else addr = narrow ? $urandom_range(0, 'hFFFF) : $urandom;

                r = $urandom_range(0, 99);
                if (r < 40) kind = RELOC_HIGHLOW;
                else if (r < 75) kind = RELOC_MOVW_MOVT;
                else if (r < 87) kind = RELOC_ABS;
                else kind = 4'($urandom);

                case (kind)
                    RELOC_HIGHLOW: push_reloc(kind, addr, $urandom);
                    RELOC_MOVW_MOVT: push_reloc(kind,
                        fixup_tracker::with_imm16($urandom, addr[15:0]), $urandom);
                    default: push_reloc(kind, $urandom, $urandom);
                endcase

                // halfway through one phase the sender waits for the block to empty
                if (p == 4 && j == n_reloc / 2) hold_until_drained();
            end
        end

        hold_until_drained();
        if (sb.patched_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never came", sb.patched_q.size()));
        end
        if (sb.errors == 0) begin
            $display("image_relocation_fixup test passed");
        end else begin
            $display("image_relocation_fixup test failed");
        end
        $finish;
    end

endmodule

### image_relocation_fixup.f
hw/rtl/rif_pkg.sv
hw/rtl/rif_sect_table.sv
hw/rtl/rif_remap.sv
hw/rtl/image_relocation_fixup.sv
tb/sv/tb_image_relocation_fixup.sv
